@@ design/quadratic_bezier_flattener_core_assert.svh @@
// Assertion macros shared by the flattener modules.
`ifndef QUADRATIC_BEZIER_FLATTENER_CORE_ASSERT_SVH
`define QUADRATIC_BEZIER_FLATTENER_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define QBF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define QBF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/qbf_pkg.sv @@
`timescale 1ns / 1ps
package qbf_pkg;
  localparam int unsigned CoordW = 25;
  localparam int unsigned FixedOneDef = 256;
  localparam int unsigned MaxSegDef = 64;
  localparam int unsigned CntW = 7;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    CMD_LINE  = 1'b0,
    CMD_CURVE = 1'b1
  } cmd_e;

  typedef logic signed [CoordW-1:0] coord_t;

  // Classified piece handed from front to back.
  typedef struct packed {
    coord_t         x0;
    coord_t         y0;
    coord_t         cx;
    coord_t         cy;
    coord_t         x1;
    coord_t         y1;
    logic [CntW-1:0] n;
  } job_t;
endpackage

@@ design/qbf_if.sv @@
`timescale 1ns / 1ps
interface qbf_in_if;
  logic                 valid;
  logic                 ready;
  logic                 command;
  qbf_pkg::coord_t      start_x;
  qbf_pkg::coord_t      start_y;
  qbf_pkg::coord_t      control_x;
  qbf_pkg::coord_t      control_y;
  qbf_pkg::coord_t      end_x;
  qbf_pkg::coord_t      end_y;
  modport source (output valid, command, start_x, start_y, control_x, control_y,
                  end_x, end_y, input ready);
  modport sink (input valid, command, start_x, start_y, control_x, control_y,
                end_x, end_y, output ready);
endinterface

interface qbf_out_if;
  logic            valid;
  logic            ready;
  qbf_pkg::coord_t seg_x0;
  qbf_pkg::coord_t seg_y0;
  qbf_pkg::coord_t seg_x1;
  qbf_pkg::coord_t seg_y1;
  logic            horizontal;
  logic            last;
  modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, horizontal, last,
                  input ready);
  modport sink (input valid, seg_x0, seg_y0, seg_x1, seg_y1, horizontal, last,
                output ready);
endinterface

@@ design/qbf_front.sv @@
`timescale 1ns / 1ps
// Classify the piece: compute the metric, then, for a curve with a nonzero metric,
// the segment count with a bit-serial square root, one result bit per cycle.
module qbf_front #(
  parameter int unsigned FixedOne = qbf_pkg::FixedOneDef,
  parameter int unsigned MaxSeg   = qbf_pkg::MaxSegDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qbf_in_if.sink        in_if,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output qbf_pkg::job_t job_o
);
  localparam int unsigned MW = qbf_pkg::CoordW + 4;
  localparam int unsigned QW = MW + 2;
  localparam int unsigned RW = 7;
  localparam int unsigned ShW = $clog2(FixedOne);

  typedef enum logic [1:0] {S_IDLE, S_ROOT, S_OUT} state_e;

  state_e state_q;
  qbf_pkg::job_t job_q;
  logic [QW-1:0] rem_q;
  logic [RW-1:0] root_q;
  logic [2:0] bit_q;
  logic root_big_q;

  logic signed [MW-1:0] dx, dy;
  logic [MW-1:0] ax, ay, metric;
  logic [QW-1:0] q_val;
  logic [RW-1:0] trial;
  logic [QW-1:0] trial_sq;
  logic big;

  always_comb begin
    dx = MW'(in_if.start_x) - MW'(in_if.control_x) - MW'(in_if.control_x)
       + MW'(in_if.end_x);
    dy = MW'(in_if.start_y) - MW'(in_if.control_y) - MW'(in_if.control_y)
       + MW'(in_if.end_y);
    ax = dx[MW-1] ? MW'(-dx) : MW'(dx);
    ay = dy[MW-1] ? MW'(-dy) : MW'(dy);
    metric = ax + ay;
    q_val = QW'({metric, 2'b00} >> ShW);
    big = (q_val >= QW'(64 * 64));
    trial = root_q | (RW'(1) << bit_q);
    trial_sq = QW'(trial) * QW'(trial);
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign job_valid_o = (state_q == S_OUT);
  assign job_o = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q <= '0;
      rem_q <= '0;
      root_q <= '0;
      bit_q <= '0;
      root_big_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_if.valid) begin
            job_q.x0 <= in_if.start_x;
            job_q.y0 <= in_if.start_y;
            job_q.cx <= in_if.control_x;
            job_q.cy <= in_if.control_y;
            job_q.x1 <= in_if.end_x;
            job_q.y1 <= in_if.end_y;
            job_q.n <= qbf_pkg::CntW'(1);
            rem_q <= q_val;
            root_q <= '0;
            bit_q <= 3'd5;
            root_big_q <= big;
            if (in_if.command == qbf_pkg::CMD_CURVE && metric != '0) begin
              state_q <= S_ROOT;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_ROOT: begin
          // one result bit per cycle, root of at most 63 when not saturated
          if (trial_sq <= rem_q) root_q <= trial;
          if (bit_q == 3'd0) begin
            state_q <= S_OUT;
            if (root_big_q) begin
              job_q.n <= qbf_pkg::CntW'(MaxSeg);
            end else begin
              job_q.n <= (qbf_pkg::CntW'((trial_sq <= rem_q) ? trial : root_q) + 1'b1
                          > qbf_pkg::CntW'(MaxSeg)) ? qbf_pkg::CntW'(MaxSeg)
                       : qbf_pkg::CntW'((trial_sq <= rem_q) ? trial : root_q) + 1'b1;
            end
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        S_OUT: begin
          if (job_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `include "quadratic_bezier_flattener_core_assert.svh"
  `QBF_ASSERT_IMPL(a_job_n_nonzero, clk_i, rst_ni, job_valid_o, job_o.n != '0)
  `QBF_ASSERT_IMPL(a_job_n_cap, clk_i, rst_ni, job_valid_o, job_o.n <= qbf_pkg::CntW'(MaxSeg))
  `QBF_ASSERT_NEXT(a_hold_job, clk_i, rst_ni, job_valid_o && !job_ready_i, job_valid_o)
endmodule

@@ design/qbf_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue between the front and back parts.
module qbf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  qbf_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output qbf_pkg::job_t pop_data_o
);
  qbf_pkg::job_t mem_q [qbf_pkg::QueueDepth];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = (cnt_q != 2'(qbf_pkg::QueueDepth));
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  `include "quadratic_bezier_flattener_core_assert.svh"
  `QBF_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= 2'(qbf_pkg::QueueDepth))
  `QBF_ASSERT_NEXT(a_cnt_push, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
  `QBF_ASSERT_NEXT(a_cnt_pop, clk_i, rst_ni, pop && !push, cnt_q == $past(cnt_q) - 2'd1)
endmodule

@@ design/qbf_back.sv @@
`timescale 1ns / 1ps
// Evaluate samples k = 1..N. Per sample and axis: weights u*u, 2ku, k*k,
// three multiplies summed, then a floor division by N*N with a restoring
// divider producing one quotient bit per cycle.
module qbf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  qbf_pkg::job_t  job_i,
  qbf_out_if.source      out_if
);
  localparam int unsigned CW = qbf_pkg::CoordW;
  localparam int unsigned WW = 13;          // weights up to 64*64
  localparam int unsigned PW = CW + WW + 2; // products and sums
  localparam int unsigned QBITS = CW + 1;
  localparam int unsigned DW = 13;          // N*N up to 4096

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_DIV, S_OUT} state_e;

  state_e state_q;
  qbf_pkg::job_t job_q;
  logic [qbf_pkg::CntW-1:0] k_q;
  logic axis_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q;
  logic [PW-1:0] mag_q;
  logic [DW:0] rem_q;
  logic [QBITS-1:0] quo_q;
  logic [$clog2(PW+1)-1:0] dcnt_q;
  logic neg_q;
  logic [DW-1:0] nsq_q;
  qbf_pkg::coord_t px_q, py_q, sx_q;
  qbf_pkg::coord_t ox0_q, oy0_q, ox1_q, oy1_q;
  logic ohz_q, olast_q, ovalid_q;

  logic [qbf_pkg::CntW-1:0] u;
  logic [WW-1:0] wu, wc, wk;
  qbf_pkg::coord_t a0, ac, a1;
  logic [DW:0] rem_sh;
  logic signed [QBITS+1:0] qfin;
  logic last_k;
  logic emit;

  always_comb begin
    u = job_q.n - k_q;
    wu = WW'(u) * WW'(u);
    wc = WW'(k_q) * WW'(u) * WW'(2);
    wk = WW'(k_q) * WW'(k_q);
    a0 = axis_q ? job_q.y0 : job_q.x0;
    ac = axis_q ? job_q.cy : job_q.cx;
    a1 = axis_q ? job_q.y1 : job_q.x1;
    rem_sh = {rem_q[DW-1:0], mag_q[PW-1]};
    qfin = neg_q ? -$signed({2'b0, quo_q} + (QBITS+2)'(rem_q != '0))
                 : $signed({2'b0, quo_q});
    last_k = (k_q == job_q.n);
    emit = (state_q == S_DIV) && (dcnt_q == '0) && axis_q
        && (!ovalid_q || out_if.ready);
  end

  assign job_ready_o = (state_q == S_IDLE);
  assign out_if.valid = ovalid_q;
  assign out_if.seg_x0 = ox0_q;
  assign out_if.seg_y0 = oy0_q;
  assign out_if.seg_x1 = ox1_q;
  assign out_if.seg_y1 = oy1_q;
  assign out_if.horizontal = ohz_q;
  assign out_if.last = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovalid_q <= 1'b0;
      job_q <= '0;
      k_q <= '0;
      axis_q <= 1'b0;
      p0_q <= '0; p1_q <= '0; p2_q <= '0;
      mag_q <= '0; rem_q <= '0; quo_q <= '0;
      dcnt_q <= '0; neg_q <= 1'b0; nsq_q <= '0;
      px_q <= '0; py_q <= '0; sx_q <= '0;
      ox0_q <= '0; oy0_q <= '0; ox1_q <= '0; oy1_q <= '0;
      ohz_q <= 1'b0; olast_q <= 1'b0;
    end else begin
      ovalid_q <= emit || (ovalid_q && !out_if.ready);
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q <= job_i;
            k_q <= qbf_pkg::CntW'(1);
            axis_q <= 1'b0;
            px_q <= job_i.x0;
            py_q <= job_i.y0;
            nsq_q <= DW'(job_i.n) * DW'(job_i.n);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          p0_q <= PW'(a0) * $signed({1'b0, wu});
          p1_q <= PW'(ac) * $signed({1'b0, wc});
          p2_q <= PW'(a1) * $signed({1'b0, wk});
          state_q <= S_SUM;
        end
        S_SUM: begin
          neg_q <= (p0_q + p1_q + p2_q) < 0;
          mag_q <= ((p0_q + p1_q + p2_q) < 0) ? -(p0_q + p1_q + p2_q)
                                              : (p0_q + p1_q + p2_q);
          rem_q <= '0;
          quo_q <= '0;
          dcnt_q <= ($clog2(PW+1))'(PW);
          state_q <= S_DIV;
        end
        S_DIV: begin
          // restoring division of the magnitude, one bit a cycle
          if (dcnt_q != '0) begin
            mag_q <= mag_q << 1;
            if (rem_sh >= {1'b0, nsq_q}) begin
              rem_q <= rem_sh - {1'b0, nsq_q};
              quo_q <= {quo_q[QBITS-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[QBITS-2:0], 1'b0};
            end
            dcnt_q <= dcnt_q - 1'b1;
          end else if (!axis_q) begin
            sx_q <= CW'(qfin);
            axis_q <= 1'b1;
            state_q <= S_MUL;
          end else if (emit) begin
            ox0_q <= px_q;
            oy0_q <= py_q;
            ox1_q <= sx_q;
            oy1_q <= CW'(qfin);
            ohz_q <= (py_q == CW'(qfin));
            olast_q <= last_k;
            px_q <= sx_q;
            py_q <= CW'(qfin);
            axis_q <= 1'b0;
            k_q <= k_q + 1'b1;
            state_q <= last_k ? S_IDLE : S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `include "quadratic_bezier_flattener_core_assert.svh"
  `QBF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, ovalid_q && !out_if.ready, ovalid_q && $stable(ox1_q))
  `QBF_ASSERT_IMPL(a_k_range, clk_i, rst_ni, state_q != S_IDLE, k_q <= job_q.n && k_q != '0)
  `QBF_ASSERT_IMPL(a_hz_flag, clk_i, rst_ni, ovalid_q, ohz_q == (oy0_q == oy1_q))
endmodule

@@ design/quadratic_bezier_flattener_core.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Payload
// in_if   | sink      | command, start/control/end x and y
// out_if  | source    | seg_x0, seg_y0, seg_x1, seg_y1, horizontal, last
// Front: a line or flat curve skips the root; a curve takes a 6-bit bit-serial root.
// Back: each segment runs the bit-serial divider once per axis; the divider is
// shared by both axes.
// Reset clears all control state at once; no clearing pass.
// The queue lets the front classify the next piece while the back is busy.
module quadratic_bezier_flattener_core #(
  parameter int unsigned FixedOne = qbf_pkg::FixedOneDef,
  parameter int unsigned MaxSeg   = qbf_pkg::MaxSegDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  qbf_in_if.sink    in_if,
  qbf_out_if.source out_if
);
  logic          f_valid, f_ready, b_valid, b_ready;
  qbf_pkg::job_t f_job, b_job;

  qbf_front #(.FixedOne(FixedOne), .MaxSeg(MaxSeg)) u_front (
    .clk_i, .rst_ni, .in_if,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  qbf_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_data_i(f_job),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_data_o(b_job)
  );

  qbf_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .out_if
  );
endmodule

@@ tb/sv/quadratic_bezier_flattener_core_tb.sv @@
`timescale 1ns / 1ps
module quadratic_bezier_flattener_core_tb;
  localparam int unsigned FIX_ONE  = qbf_pkg::FixedOneDef;
  localparam int unsigned SEG_CAP  = qbf_pkg::MaxSegDef;
  localparam int unsigned IDLE_LIM = 20000;

  typedef struct packed {
    logic            cmd;
    qbf_pkg::coord_t x0;
    qbf_pkg::coord_t y0;
    qbf_pkg::coord_t cx;
    qbf_pkg::coord_t cy;
    qbf_pkg::coord_t x1;
    qbf_pkg::coord_t y1;
  } piece_t;

  typedef struct packed {
    qbf_pkg::coord_t ax;
    qbf_pkg::coord_t ay;
    qbf_pkg::coord_t bx;
    qbf_pkg::coord_t by;
    logic            horiz;
    logic            fin;
  } seg_t;

  typedef struct {
    piece_t pc;
    bit     known;
    seg_t   seg;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qbf_in_if  pin ();
  qbf_out_if pout ();

  quadratic_bezier_flattener_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (pin.sink),
    .out_if(pout.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  seg_t   seg_q[$];
  seg_t   seg_known_q[$];
  bit     known_q[$];
  row_t   rows[$];
  int     errors = 0;
  int     segs_seen = 0;
  int     curves_sent = 0;
  int     capped_seen = 0;
  int     idle_cycles = 0;
  bit     stim_done = 1'b0;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint isqrt(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v && r < 70) r++;
    return r;
  endfunction

  function automatic longint sample(longint p0, longint c, longint p1, longint k, longint n);
    longint u;
    u = n - k;
    return floor_div(u * u * p0 + 2 * k * u * c + k * k * p1, n * n);
  endfunction

  function automatic seg_t mk_seg(longint ax, longint ay, longint bx, longint by, bit fin);
    seg_t s;
    s.ax = qbf_pkg::coord_t'(ax);
    s.ay = qbf_pkg::coord_t'(ay);
    s.bx = qbf_pkg::coord_t'(bx);
    s.by = qbf_pkg::coord_t'(by);
    s.horiz = (ay == by);
    s.fin = fin;
    return s;
  endfunction

  // Queue the segments this piece flattens into.
  task automatic flatten_piece(piece_t pc);
    longint x0, y0, cx, cy, x1, y1, m, r, n, px, py, nx, ny;
    x0 = pc.x0; y0 = pc.y0; cx = pc.cx; cy = pc.cy; x1 = pc.x1; y1 = pc.y1;
    if (pc.cmd == qbf_pkg::CMD_LINE) begin
      seg_q = {seg_q, mk_seg(x0, y0, x1, y1, 1'b1)};
      return;
    end
    curves_sent++;
    m = ((x0 - 2 * cx + x1) < 0 ? -(x0 - 2 * cx + x1) : (x0 - 2 * cx + x1)) +
        ((y0 - 2 * cy + y1) < 0 ? -(y0 - 2 * cy + y1) : (y0 - 2 * cy + y1));
    n = 1;
    if (m > 0) begin
      r = isqrt(floor_div(m * 4, FIX_ONE));
      n = (r >= SEG_CAP) ? SEG_CAP : r + 1;
    end
    if (n == SEG_CAP) capped_seen++;
    px = x0;
    py = y0;
    for (longint k = 1; k <= n; k++) begin
      nx = sample(x0, cx, x1, k, n);
      ny = sample(y0, cy, y1, k, n);
      seg_q = {seg_q, mk_seg(px, py, nx, ny, k == n)};
      px = nx;
      py = ny;
    end
  endtask

  task automatic report(string what, seg_t got, seg_t want);
    errors++;
    $display("mismatch %0s: got %h want %h", what, got, want);
  endtask

  function automatic qbf_pkg::coord_t rnd_coord(int mode);
    case (mode)
      0: return qbf_pkg::coord_t'($urandom);
      1: return qbf_pkg::coord_t'($urandom_range(0, 16777216) - 8388608);
      default: return qbf_pkg::coord_t'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  function automatic piece_t rnd_piece();
    piece_t p;
    int mode;
    mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 3) == 0 ? 1 : 2);
    p.cmd = ($urandom_range(0, 3) == 0) ? qbf_pkg::CMD_LINE : qbf_pkg::CMD_CURVE;
    p.x0 = rnd_coord(mode);
    p.y0 = rnd_coord(mode);
    p.x1 = rnd_coord(mode);
    p.y1 = $urandom_range(0, 5) == 0 ? p.y0 : rnd_coord(mode);
    p.cx = rnd_coord(mode);
    p.cy = rnd_coord(mode);
    if ($urandom_range(0, 7) == 0) begin
      // put the control point on the chord midpoint
      p.cx = qbf_pkg::coord_t'((longint'(p.x0) + longint'(p.x1)) / 2);
      p.cy = qbf_pkg::coord_t'((longint'(p.y0) + longint'(p.y1)) / 2);
    end
    return p;
  endfunction

  function automatic piece_t pc(logic c, int x0, int y0, int cx, int cy, int x1, int y1);
    piece_t p;
    p = '{c, qbf_pkg::coord_t'(x0), qbf_pkg::coord_t'(y0), qbf_pkg::coord_t'(cx),
          qbf_pkg::coord_t'(cy), qbf_pkg::coord_t'(x1), qbf_pkg::coord_t'(y1)};
    return p;
  endfunction

  task automatic add_row(piece_t p, bit known, seg_t s);
    row_t r;
    r.pc = p;
    r.known = known;
    r.seg = s;
    rows = {rows, r};
  endtask

  // Input driver.
  initial begin
    piece_t p;
    int gap;
    pin.valid <= 1'b0;
    pin.command <= qbf_pkg::CMD_LINE;
    {pin.start_x, pin.start_y, pin.control_x, pin.control_y, pin.end_x, pin.end_y}
      <= '0;
    add_row(pc(qbf_pkg::CMD_LINE, 0, 0, 0, 0, 0, 0), 1'b1, mk_seg(0, 0, 0, 0, 1'b1));
    add_row(pc(qbf_pkg::CMD_LINE, -8388608, 8388607, 5, 5, 8388607, -8388608), 1'b1,
            mk_seg(-8388608, 8388607, 8388607, -8388608, 1'b1));
    add_row(pc(qbf_pkg::CMD_LINE, 100, 7, 0, 0, -100, 7), 1'b1,
            mk_seg(100, 7, -100, 7, 1'b1));
    add_row(pc(qbf_pkg::CMD_CURVE, 0, 0, 500, 500, 1000, 1000), 1'b1,
            mk_seg(0, 0, 1000, 1000, 1'b1));
    add_row(pc(qbf_pkg::CMD_CURVE, -8388608, -8388608, -8388608, -8388608,
               -8388608, -8388608),
            1'b1, mk_seg(-8388608, -8388608, -8388608, -8388608, 1'b1));
    add_row(pc(qbf_pkg::CMD_CURVE, 0, 0, 64, 0, 0, 0), 1'b0, '0);
    add_row(pc(qbf_pkg::CMD_CURVE, 0, 0, 63, 0, 0, 0), 1'b0, '0);
    add_row(pc(qbf_pkg::CMD_CURVE, 0, 0, 8388607, 8388607, 0, 0), 1'b0, '0);
    add_row(pc(qbf_pkg::CMD_CURVE, -8388608, 8388607, 8388607, -8388608, -8388608,
               8388607), 1'b0, '0);
    add_row(pc(qbf_pkg::CMD_CURVE, 8388607, -8388608, -8388608, 8388607, -8388608,
               8388607), 1'b0, '0);
    add_row(pc(qbf_pkg::CMD_CURVE, 0, 0, 1000, 3, 2000, 0), 1'b0, '0);
    add_row(pc(qbf_pkg::CMD_CURVE, 10, 10, -300, -700, 10, 10), 1'b0, '0);
    add_row(pc(qbf_pkg::CMD_CURVE, -5, 7, 13, -29, 41, 3), 1'b0, '0);
    add_row(pc(qbf_pkg::CMD_CURVE, 0, 0, 1, 1, 0, 0), 1'b0, '0);
    add_row(pc(qbf_pkg::CMD_LINE, -1, -1, -1, -1, -1, -1), 1'b1,
            mk_seg(-1, -1, -1, -1, 1'b1));
    for (int i = 0; i < 455; i++) add_row(rnd_piece(), 1'b0, '0);
    wait (rst_ni);
    foreach (rows[i]) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        pin.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pin.valid <= 1'b1;
      {pin.command, pin.start_x, pin.start_y, pin.control_x, pin.control_y,
       pin.end_x, pin.end_y} <= rows[i].pc;
      @(posedge clk_i);
      while (!pin.ready) @(posedge clk_i);
      flatten_piece(rows[i].pc);
      if (rows[i].known) begin
        known_q = {known_q, 1'b1};
        seg_known_q = {seg_known_q, rows[i].seg};
      end else begin
        known_q = {known_q, 1'b0};
      end
    end
    pin.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Output sink and checker.
  initial begin
    int stall;
    seg_t got, want, tbl;
    pout.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        pout.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pout.ready <= 1'b1;
      @(posedge clk_i);
      while (!pout.valid) @(posedge clk_i);
      got = '{pout.seg_x0, pout.seg_y0, pout.seg_x1, pout.seg_y1,
              pout.horizontal, pout.last};
      segs_seen++;
      if (seg_q.size() == 0) begin
        report("unexpected segment", got, '0);
      end else begin
        want = seg_q.pop_front();
        if (got.ax !== want.ax) report("seg_x0", got, want);
        if (got.ay !== want.ay) report("seg_y0", got, want);
        if (got.bx !== want.bx) report("seg_x1", got, want);
        if (got.by !== want.by) report("seg_y1", got, want);
        if (got.horiz !== want.horiz) report("horizontal", got, want);
        if (got.fin !== want.fin) report("last", got, want);
        if (want.fin && known_q.size() > 0) begin
          if (known_q.pop_front()) begin
            tbl = seg_known_q.pop_front();
            if (got !== tbl) report("table row", got, tbl);
          end
        end
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      if ((pin.valid && pin.ready) || (pout.valid && pout.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIM) begin
        $display("watchdog expired, %0d segments outstanding", seg_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
      if (stim_done && seg_q.size() == 0) begin
        repeat (200) @(posedge clk_i);
        $display("covered %0d pieces (%0d curves, %0d at the segment cap), %0d segments",
                 rows.size(), curves_sent, capped_seen, segs_seen);
        if (errors == 0 && seg_q.size() == 0) begin
          $display("RESULT: OK");
        end else begin
          $display("RESULT: ERROR");
        end
        $finish;
      end
    end
  end
endmodule
